// File: rtl/box_downsample_with_remainder_macros.svh
// Assertion macros for the box downsampler.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef BOX_DOWNSAMPLE_WITH_REMAINDER_MACROS_SVH
`define BOX_DOWNSAMPLE_WITH_REMAINDER_MACROS_SVH

// Property checked outside reset only.
`define BDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked at every edge, reset included.
`define BDR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/bdr_pkg.sv
// Shared types and constants for the box downsampler.
// No dependencies.
package bdr_pkg;

  localparam int unsigned MaxSrcWidth  = 4096;
  localparam int unsigned MaxDstWidth  = 1024;
  localparam int unsigned SrcHeightLim = 4096;
  localparam int unsigned DstHeightLim = 1024;

  localparam int unsigned ColAw = $clog2(MaxDstWidth);

  typedef enum logic [2:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SDIV,
    ST_SMUL,
    ST_IDLE,
    ST_RMW,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

// File: rtl/bdr_pix_if.sv
// Pixel input channel: valid/ready handshake with one 8-bit pixel.
// No dependencies.
interface bdr_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

// File: rtl/bdr_res_if.sv
// Result channel: valid/ready handshake with average and block position.
// No dependencies.
interface bdr_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] average;
  logic [9:0] out_col;
  logic [9:0] out_row;
  logic       frame_last;

  modport source (output valid, output average, output out_col, output out_row,
                  output frame_last, input ready);
  modport sink (input valid, input average, input out_col, input out_row,
                input frame_last, output ready);
endinterface

// File: rtl/box_downsample_with_remainder.sv
// Area-averaging downsampler; uses bdr_pkg, bdr_pix_if, bdr_res_if and the macro header.
// Steps: a pixel is accepted, then read-modify-written into its column sum; a pixel that
// closes a block then runs the 8-step quotient loop and is registered at the output.
// A new pixel is taken only once the last one is through, and not while the output
// register waits on the sink. Reset (async, active low) and writes to the four size
// registers start setup; sums not cleared.
`include "box_downsample_with_remainder_macros.svh"

module box_downsample_with_remainder import bdr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  bdr_pix_if.sink     pix_i,
  bdr_res_if.source   res_o
);

  // Configuration and derived block geometry
  logic [12:0] sw_q, sh_q;
  logic [10:0] tw_q, th_q;
  logic [12:0] kw_q, kh_q, bwl_q, bhl_q;
  logic        cfg_ok_q;

  // Setup divider (block width and height)
  logic [12:0] dvd_q, rem_q, quo_q;
  logic [3:0]  sstep_q;
  logic        phase_q;

  // Raster position
  logic [11:0] sx_q, sy_q, xb_q, yb_q;
  logic [9:0]  bc_q, br_q;

  // Per-pixel datapath
  logic [7:0]  pix_q;
  logic [31:0] rd_q;
  logic [31:0] drem_q;
  logic [24:0] cnt_q;
  logic [2:0]  dstep_q;
  logic [7:0]  avg_q;
  logic [9:0]  col_q, row_q;
  logic        last_q;

  // Output register
  logic        rv_q;
  logic [7:0]  ravg_q;
  logic [9:0]  rcol_q, rrow_q;
  logic        rlast_q;

  logic [31:0] col_mem [MaxDstWidth];

  state_e state_q, state_d;

  // Current block geometry
  logic        is_last_col, is_last_row;
  logic [12:0] bw_cur, bh_cur;
  assign is_last_col = ({1'b0, bc_q} == (tw_q - 11'd1));
  assign is_last_row = ({1'b0, br_q} == (th_q - 11'd1));
  assign bw_cur = is_last_col ? bwl_q : kw_q;
  assign bh_cur = is_last_row ? bhl_q : kh_q;

  logic blk_end, blk_first;
  assign blk_end = ({1'b0, xb_q} == bw_cur - 13'd1) && ({1'b0, yb_q} == bh_cur - 13'd1);
  assign blk_first = (xb_q == 12'd0) && (yb_q == 12'd0);

  logic [31:0] sum_new;
  assign sum_new = blk_first ? {24'd0, pix_q} : rd_q + {24'd0, pix_q};

  // Setup divider step
  logic [10:0] sdvs;
  logic [12:0] srem_sh;
  logic        sge;
  assign sdvs    = phase_q ? th_q : tw_q;
  assign srem_sh = {rem_q[11:0], dvd_q[12]};
  assign sge     = (srem_sh >= {2'b00, sdvs});

  // Last-column and last-row sizes
  logic [23:0] wprod, hprod;
  assign wprod = (tw_q - 11'd1) * kw_q;
  assign hprod = (th_q - 11'd1) * kh_q;

  // Quotient step for the block average
  logic [31:0] trial;
  logic        dge;
  assign trial = {7'd0, cnt_q} << dstep_q;
  assign dge   = (drem_q >= trial);

  logic [25:0] cnt_prod;
  assign cnt_prod = bw_cur * bh_cur;

  logic out_free;
  assign out_free = !rv_q || res_o.ready;

  assign pix_i.ready = (state_q == ST_IDLE);
  logic pix_acc;
  assign pix_acc = pix_i.valid && pix_i.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: state_d = ST_SDIV;
      ST_SDIV: begin
        if (sstep_q == 4'd12) state_d = phase_q ? ST_SMUL : ST_LOAD;
      end
      ST_SMUL: state_d = ST_IDLE;
      ST_IDLE: begin
        if (pix_acc && cfg_ok_q) state_d = ST_RMW;
      end
      ST_RMW:  state_d = blk_end ? ST_DIV : ST_IDLE;
      ST_DIV: begin
        if (dstep_q == 3'd0) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_LOAD;
    endcase
    // a write to one of the four size registers restarts setup
    if (cfg_we_i && (cfg_idx_i inside {REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_DST_WIDTH,
                                       REG_DST_HEIGHT})) begin
      state_d = ST_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Column sum memory: registered read, write-back in the modify cycle
  always_ff @(posedge clk_i) begin
    rd_q <= col_mem[bc_q];
    if (state_q == ST_RMW) begin
      col_mem[bc_q] <= sum_new;
    end
  end

  logic [12:0] sx_n, xb_n, sy_n, yb_n;
  assign sx_n = {1'b0, sx_q} + 13'd1;
  assign xb_n = {1'b0, xb_q} + 13'd1;
  assign sy_n = {1'b0, sy_q} + 13'd1;
  assign yb_n = {1'b0, yb_q} + 13'd1;

  // Control state: configuration, phase, position, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= 13'd1; sh_q <= 13'd1; tw_q <= 11'd1; th_q <= 11'd1;
      phase_q <= 1'b0; cfg_ok_q <= 1'b0;
      sx_q <= '0; sy_q <= '0; xb_q <= '0; yb_q <= '0; bc_q <= '0; br_q <= '0;
      rv_q <= 1'b0;
    end else begin
      if (rv_q && res_o.ready) rv_q <= 1'b0;
      if (state_q == ST_OUT && out_free) rv_q <= 1'b1;
      if (state_q == ST_SDIV && sstep_q == 4'd12) phase_q <= ~phase_q;
      if (state_q == ST_SMUL) begin
        cfg_ok_q <= (tw_q != 11'd0) && (th_q != 11'd0) && (sw_q != 13'd0) &&
                    (sh_q != 13'd0) && ({2'b00, tw_q} <= sw_q) &&
                    ({2'b00, th_q} <= sh_q) && (sw_q <= 13'(MaxSrcWidth)) &&
                    (tw_q <= 11'(MaxDstWidth)) && (sh_q <= 13'(SrcHeightLim)) &&
                    (th_q <= 11'(DstHeightLim));
      end
      if (state_q == ST_RMW) begin
        // advance the raster position
        sx_q <= sx_n[11:0];
        if (xb_n >= bw_cur) begin
          xb_q <= '0;
          bc_q <= bc_q + 10'd1;
        end else begin
          xb_q <= xb_n[11:0];
        end
        if (sx_n >= sw_q) begin
          sx_q <= '0; bc_q <= '0; xb_q <= '0;
          sy_q <= sy_n[11:0];
          if (yb_n >= bh_cur) begin
            yb_q <= '0;
            br_q <= br_q + 10'd1;
          end else begin
            yb_q <= yb_n[11:0];
          end
          if (sy_n >= sh_q) begin
            sy_q <= '0; br_q <= '0; yb_q <= '0;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SRC_WIDTH:  sw_q <= cfg_data_i;
          REG_SRC_HEIGHT: sh_q <= cfg_data_i;
          REG_DST_WIDTH:  tw_q <= cfg_data_i[10:0];
          REG_DST_HEIGHT: th_q <= cfg_data_i[10:0];
          default: ;
        endcase
        if (cfg_idx_i inside {REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_DST_WIDTH,
                              REG_DST_HEIGHT}) begin
          phase_q <= 1'b0; cfg_ok_q <= 1'b0;
          sx_q <= '0; sy_q <= '0; xb_q <= '0; yb_q <= '0; bc_q <= '0; br_q <= '0;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_LOAD: begin
        dvd_q   <= phase_q ? sh_q : sw_q;
        rem_q   <= '0;
        sstep_q <= '0;
      end
      ST_SDIV: begin
        rem_q   <= sge ? srem_sh - {2'b00, sdvs} : srem_sh;
        quo_q   <= {quo_q[11:0], sge};
        dvd_q   <= {dvd_q[11:0], 1'b0};
        sstep_q <= sstep_q + 4'd1;
        if (sstep_q == 4'd12) begin
          if (phase_q) kh_q <= {quo_q[11:0], sge};
          else kw_q <= {quo_q[11:0], sge};
        end
      end
      ST_SMUL: begin
        bwl_q <= sw_q - wprod[12:0];
        bhl_q <= sh_q - hprod[12:0];
      end
      ST_IDLE: begin
        if (pix_acc) pix_q <= pix_i.pixel_in;
      end
      ST_RMW: begin
        drem_q  <= sum_new;
        cnt_q   <= cnt_prod[24:0];
        dstep_q <= 3'd7;
        col_q   <= bc_q;
        row_q   <= br_q;
        last_q  <= is_last_col && is_last_row;
      end
      ST_DIV: begin
        if (dge) drem_q <= drem_q - trial;
        avg_q   <= {avg_q[6:0], dge};
        dstep_q <= dstep_q - 3'd1;
      end
      ST_OUT: begin
        if (out_free) begin
          ravg_q  <= avg_q;
          rcol_q  <= col_q;
          rrow_q  <= row_q;
          rlast_q <= last_q;
        end
      end
      default: ;
    endcase
  end

  assign res_o.valid      = rv_q;
  assign res_o.average    = ravg_q;
  assign res_o.out_col    = rcol_q;
  assign res_o.out_row    = rrow_q;
  assign res_o.frame_last = rlast_q;

  `BDR_ASSERT(a_div_nonzero, (state_q == ST_DIV) |-> (cnt_q != 25'd0), "zero block count")
  `BDR_ASSERT(a_cfg_blocks, cfg_we_i && (cfg_idx_i == REG_SRC_WIDTH) |=> !pix_i.ready, "setup")
  `BDR_ASSERT(a_rmw_valid, (state_q == ST_RMW) |-> cfg_ok_q, "pixel processed under invalid settings")
  `BDR_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !res_o.valid, "result during reset")

endmodule

// File: bench/box_downsample_with_remainder_test.sv
// Self-checking bench for box_downsample_with_remainder: directed table, then random frames.
// Depends on bdr_pkg, bdr_pix_if, bdr_res_if and the block itself.
module box_downsample_with_remainder_test;
  import bdr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Index past the end of the register list: must change nothing.
  localparam logic [2:0] RegBeyond = 3'd5;
  // Settle time after the last result before a register write.
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned RandomPixels = 1100;

  typedef struct packed {
    logic [7:0] average;
    logic [9:0] out_col;
    logic [9:0] out_row;
    logic       frame_last;
  } area_res_t;

  typedef enum logic [1:0] { ROW_CFG, ROW_PIX, ROW_DRAIN } row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic [2:0] idx;
    logic [12:0] data;   // register value, or pixel value
    int unsigned count;  // pixels to send with this value
    bit          typed;  // expected result typed in for the last pixel
    area_res_t   res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [12:0] cfg_data_i = '0;

  bdr_pix_if pix ();
  bdr_res_if res ();

  box_downsample_with_remainder dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .pix_i(pix.sink), .res_o(res.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Area-average predictor: own copy of the settings and position counters
  // ---------------------------------------------------------------------------
  logic [12:0] src_w, src_h;
  logic [10:0] dst_w, dst_h;
  int unsigned col_x, row_y, blk_col, blk_x, blk_row, blk_y;
  logic [31:0] col_sum [MaxDstWidth];

  area_res_t expected_q [$];
  int unsigned fail_count = 0;

  // Travels with the pixel: its result is the typed-in one in typed_res.
  bit        pix_typed = 1'b0;
  area_res_t typed_res;

  function automatic bit area_valid();
    if (src_w == 0 || src_h == 0 || dst_w == 0 || dst_h == 0) return 0;
    if (dst_w > src_w || dst_h > src_h) return 0;
    if (src_w > MaxSrcWidth || dst_w > MaxDstWidth) return 0;
    if (src_h > SrcHeightLim || dst_h > DstHeightLim) return 0;
    return 1;
  endfunction

  function void clear_position();
    col_x = 0; row_y = 0; blk_col = 0; blk_x = 0; blk_row = 0; blk_y = 0;
  endfunction

  function void write_area_reg(input logic [2:0] idx, input logic [12:0] data);
    case (idx)
      REG_SRC_WIDTH:  begin src_w = data; clear_position(); end
      REG_SRC_HEIGHT: begin src_h = data; clear_position(); end
      REG_DST_WIDTH:  begin dst_w = data[10:0]; clear_position(); end
      REG_DST_HEIGHT: begin dst_h = data[10:0]; clear_position(); end
      default: ;
    endcase
  endfunction

  // Accumulate one pixel; return the block average when it closes a block.
  function void average_pixel(input logic [7:0] p, output bit got, output area_res_t r);
    int unsigned kw, kh, bw, bh, ci;
    got = 0;
    r = '0;
    if (!area_valid()) return;
    kw = src_w / dst_w;
    kh = src_h / dst_h;
    bw = (blk_col == dst_w - 1) ? src_w - (dst_w - 1) * kw : kw;
    bh = (blk_row == dst_h - 1) ? src_h - (dst_h - 1) * kh : kh;
    ci = (blk_col >= MaxDstWidth) ? MaxDstWidth - 1 : blk_col;
    if (blk_x == 0 && blk_y == 0) col_sum[ci] = 32'(p);
    else col_sum[ci] = col_sum[ci] + 32'(p);
    if (blk_x == bw - 1 && blk_y == bh - 1) begin
      got = 1;
      r.average    = 8'(col_sum[ci] / (bw * bh));
      r.out_col    = 10'(blk_col);
      r.out_row    = 10'(blk_row);
      r.frame_last = (blk_col == dst_w - 1) && (blk_row == dst_h - 1);
    end
    col_x++;
    blk_x++;
    if (blk_x >= bw) begin
      blk_x = 0;
      blk_col++;
    end
    if (col_x >= src_w) begin
      col_x = 0; blk_col = 0; blk_x = 0;
      row_y++;
      blk_y++;
      if (blk_y >= bh) begin
        blk_y = 0;
        blk_row++;
      end
      if (row_y >= src_h) begin
        row_y = 0; blk_row = 0; blk_y = 0;
      end
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitors: predict on every accepted pixel, check every accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bit got;
    area_res_t r;
    if (rst_ni && pix.valid && pix.ready) begin
      average_pixel(pix.pixel_in, got, r);
      if (pix_typed) begin
        // the typed value stands in for the predicted one on this row
        got = 1;
        r = typed_res;
      end
      if (got) expected_q.push_back(r);
    end
  end

  always @(posedge clk_i) begin
    area_res_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result avg=%0d col=%0d row=%0d",
                                  res.average, res.out_col, res.out_row));
      end else begin
        want = expected_q.pop_front();
        if (res.average !== want.average)
          report_mismatch($sformatf("average %0d, want %0d", res.average, want.average));
        if (res.out_col !== want.out_col)
          report_mismatch($sformatf("out_col %0d, want %0d", res.out_col, want.out_col));
        if (res.out_row !== want.out_row)
          report_mismatch($sformatf("out_row %0d, want %0d", res.out_row, want.out_row));
        if (res.frame_last !== want.frame_last)
          report_mismatch($sformatf("frame_last %0b, want %0b", res.frame_last,
                                    want.frame_last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall pattern whose density changes now and then, plus
  // one long hold-off on request so the block backs up and stalls its input
  // ---------------------------------------------------------------------------
  bit hold_request = 0;

  initial begin
    int unsigned stall_pct;
    int unsigned left;
    res.ready = 1'b0;
    stall_pct = 0;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        res.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_request = 0;
      end
      if (left == 0) begin
        // pick a new phase: no stalls, light stalls or heavy stalls
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 25;
          default: stall_pct = 75;
        endcase
        left = $urandom_range(20, 300);
      end
      left--;
      res.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;

  task automatic send_pixel(input logic [7:0] p, input bit typed = 1'b0);
    if (burst_left == 0) begin
      pix.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      // long bursts are common so there are stretches with no gaps at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    pix.valid    <= 1'b1;
    pix.pixel_in <= p;
    pix_typed    <= typed;
    do @(posedge clk_i); while (!pix.ready);
  endtask

  // Drop valid, wait for every expected result, then let in-flight pixels settle.
  task automatic drain_results();
    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One write transaction, then idle with the enable low.
  task automatic write_reg(input logic [2:0] idx, input logic [12:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    write_area_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_area(input logic [12:0] sw, input logic [12:0] sh,
                          input logic [12:0] tw, input logic [12:0] th);
    drain_results();
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, tw);
    write_reg(REG_DST_HEIGHT, th);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  stim_row_t table_rows [$];

  function automatic stim_row_t row(input row_kind_e k, input logic [2:0] idx,
                                    input logic [12:0] data, input int unsigned count,
                                    input bit typed, input area_res_t r);
    stim_row_t s;
    s.kind = k; s.idx = idx; s.data = data; s.count = count; s.typed = typed; s.res = r;
    return s;
  endfunction

  function automatic area_res_t ar(input int a, input int c, input int rw, input bit l);
    ar = '{8'(a), 10'(c), 10'(rw), l};
  endfunction

  initial begin
    // settings after reset are 1x1 to 1x1: each pixel is its own frame
    table_rows.push_back(row(ROW_PIX, 0, 13'd0, 1, 1, ar(0, 0, 0, 1)));
    table_rows.push_back(row(ROW_PIX, 0, 13'd255, 1, 1, ar(255, 0, 0, 1)));
    table_rows.push_back(row(ROW_PIX, 0, 13'hA5, 1, 1, ar(165, 0, 0, 1)));
    table_rows.push_back(row(ROW_DRAIN, 0, 0, 0, 0, '0));
    // ragged blocks: 5x3 source into 2x2, remainder in last column and row
    table_rows.push_back(row(ROW_CFG, REG_SRC_WIDTH, 13'd5, 0, 0, '0));
    table_rows.push_back(row(ROW_CFG, REG_SRC_HEIGHT, 13'd3, 0, 0, '0));
    table_rows.push_back(row(ROW_CFG, REG_DST_WIDTH, 13'd2, 0, 0, '0));
    table_rows.push_back(row(ROW_CFG, REG_DST_HEIGHT, 13'd2, 0, 0, '0));
    table_rows.push_back(row(ROW_PIX, 0, 13'd200, 15, 0, '0));
    table_rows.push_back(row(ROW_PIX, 0, 13'd7, 15, 0, '0));
    table_rows.push_back(row(ROW_DRAIN, 0, 0, 0, 0, '0));
    // target wider than source: pixels are dropped
    table_rows.push_back(row(ROW_CFG, REG_DST_WIDTH, 13'd6, 0, 0, '0));
    table_rows.push_back(row(ROW_PIX, 0, 13'd99, 4, 0, '0));
    // upper bits above an 11-bit register are ignored: width becomes 2 again
    table_rows.push_back(row(ROW_CFG, REG_DST_WIDTH, 13'h1802, 0, 0, '0));
    // a write past the register list changes nothing
    table_rows.push_back(row(ROW_CFG, RegBeyond, 13'h1FFF, 0, 0, '0));
    table_rows.push_back(row(ROW_PIX, 0, 13'd128, 15, 0, '0));
    table_rows.push_back(row(ROW_DRAIN, 0, 0, 0, 0, '0));
    // source width over the limit, then a zero register: both invalid
    table_rows.push_back(row(ROW_CFG, REG_SRC_WIDTH, 13'h1FFF, 0, 0, '0));
    table_rows.push_back(row(ROW_PIX, 0, 13'd1, 3, 0, '0));
    table_rows.push_back(row(ROW_CFG, REG_SRC_WIDTH, 13'd5, 0, 0, '0));
    table_rows.push_back(row(ROW_CFG, REG_DST_HEIGHT, 13'd0, 0, 0, '0));
    table_rows.push_back(row(ROW_PIX, 0, 13'd2, 3, 0, '0));
    // one wide row: 64 pixels into 16 columns
    table_rows.push_back(row(ROW_CFG, REG_SRC_WIDTH, 13'd64, 0, 0, '0));
    table_rows.push_back(row(ROW_CFG, REG_SRC_HEIGHT, 13'd1, 0, 0, '0));
    table_rows.push_back(row(ROW_CFG, REG_DST_WIDTH, 13'd16, 0, 0, '0));
    table_rows.push_back(row(ROW_CFG, REG_DST_HEIGHT, 13'd1, 0, 0, '0));
    table_rows.push_back(row(ROW_PIX, 0, 13'd255, 64, 0, '0));
    // the whole row as one block: average of full scale stays 255
    table_rows.push_back(row(ROW_CFG, REG_DST_WIDTH, 13'd1, 0, 0, '0));
    table_rows.push_back(row(ROW_PIX, 0, 13'd255, 64, 1, ar(255, 0, 0, 1)));
    // one tall column: 64 rows into 16
    table_rows.push_back(row(ROW_CFG, REG_SRC_WIDTH, 13'd1, 0, 0, '0));
    table_rows.push_back(row(ROW_CFG, REG_SRC_HEIGHT, 13'd64, 0, 0, '0));
    table_rows.push_back(row(ROW_CFG, REG_DST_HEIGHT, 13'd16, 0, 0, '0));
    table_rows.push_back(row(ROW_PIX, 0, 13'd0, 64, 0, '0));
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned sent;
    int unsigned frame_px;
    int unsigned sw, sh, tw, th;
    bit held;
    bit paused;
    pix.valid    = 1'b0;
    pix.pixel_in = '0;
    src_w = 13'd1; src_h = 13'd1; dst_w = 11'd1; dst_h = 11'd1;
    clear_position();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i]) begin
      case (table_rows[i].kind)
        ROW_CFG: begin
          drain_results();
          write_reg(table_rows[i].idx, table_rows[i].data);
        end
        ROW_DRAIN: drain_results();
        default: begin
          if (table_rows[i].typed) typed_res <= table_rows[i].res;
          for (int unsigned n = 0; n < table_rows[i].count; n++) begin
            // constant rows stay constant; table value is the pixel
            send_pixel(table_rows[i].data[7:0],
                       table_rows[i].typed && (n == table_rows[i].count - 1));
          end
        end
      endcase
    end

    // random frames, mostly small, now and then a wider one
    sent = 0;
    held = 0;
    paused = 0;
    while (sent < RandomPixels) begin
      if ($urandom_range(0, 9) == 0) begin
        sw = $urandom_range(16, 80);
        sh = $urandom_range(1, 6);
      end else begin
        sw = $urandom_range(1, 12);
        sh = $urandom_range(1, 8);
      end
      tw = $urandom_range(1, sw);
      th = $urandom_range(1, sh);
      if ($urandom_range(0, 11) == 0) begin
        // broken setting: the pixels are ignored and do not count
        set_area(13'(sw), 13'(sh), 13'(sw + 1), 13'(th));
        repeat (5) send_pixel(8'($urandom));
        continue;
      end
      set_area(13'(sw), 13'(sh), 13'(tw), 13'(th));
      frame_px = sw * sh * $urandom_range(1, 2);
      // some frames are cut short by the next setting
      if ($urandom_range(0, 5) == 0) frame_px = $urandom_range(1, frame_px);
      if (frame_px > RandomPixels - sent) frame_px = RandomPixels - sent;
      if (!held && sent > 300 && tw * th > 3) begin
        hold_request = 1;
        held = 1;
      end
      for (int unsigned n = 0; n < frame_px; n++) begin
        send_pixel(8'($urandom));
        sent++;
      end
      if (!paused && sent > 800) begin
        // quiet sender: let the block empty out completely mid-run
        drain_results();
        paused = 1;
      end
    end

    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: box_downsample_with_remainder.f
+incdir+rtl
rtl/bdr_pkg.sv
rtl/bdr_pix_if.sv
rtl/bdr_res_if.sv
rtl/box_downsample_with_remainder.sv
bench/box_downsample_with_remainder_test.sv
